// ===== hw/rtl/utf8sd_pkg.sv =====
`default_nettype none

package utf8sd_pkg;

   localparam int unsigned CpW    = 21;
   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW  = $clog2(QDepth);
   localparam int unsigned QCntW  = $clog2(QDepth + 1);

   localparam logic [CpW-1:0] SpaceCp = 21'h000020;

   // One queue entry: a run of spaces for dropped bytes, then an optional code point.
   typedef struct packed {
      logic [1:0]     spaces;
      logic           has_tail;
      logic [CpW-1:0] tail;
   } job_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8sd_front.sv =====
`default_nettype none

module utf8sd_front
   import utf8sd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic           req_end_of_text,
   output      logic           push,
   output      job_type        job
);

   logic [1:0]     held_ff, held_in;
   logic [1:0]     need_ff, need_in;
   logic [CpW-1:0] acc_ff, acc_in;
   logic [CpW-1:0] acc_next;
   logic           is_cont;
   logic           start;

   assign is_cont  = (req_data_byte & 8'hC0) == 8'h80;
   assign acc_next = {acc_ff[CpW-7:0], req_data_byte[5:0]};

   always_comb begin
      held_in      = held_ff;
      need_in      = need_ff;
      acc_in       = acc_ff;
      job.spaces   = 2'd0;
      job.has_tail = 1'b0;
      job.tail     = '0;
      start        = 1'b0;

      if (req_end_of_text) begin
         job.spaces = held_ff;
         held_in    = 2'd0;
         need_in    = 2'd0;
         acc_in     = '0;
      end else if (held_ff != 2'd0 && need_ff != 2'd0) begin
         if (is_cont) begin
            acc_in  = acc_next;
            held_in = held_ff + 2'd1;
            need_in = need_ff - 2'd1;
            if (need_ff == 2'd1) begin
               job.has_tail = 1'b1;
               job.tail     = acc_next;
               held_in      = 2'd0;
               need_in      = 2'd0;
               acc_in       = '0;
            end
         end else begin
            // drop the open sequence, then treat this byte as a new lead
            job.spaces = held_ff;
            held_in    = 2'd0;
            need_in    = 2'd0;
            acc_in     = '0;
            start      = 1'b1;
         end
      end else begin
         held_in = 2'd0;
         need_in = 2'd0;
         acc_in  = '0;
         start   = 1'b1;
      end

      if (start) begin
         case (req_data_byte) inside
            8'b0???_????: begin
               job.has_tail = 1'b1;
               job.tail     = {{(CpW-8){1'b0}}, req_data_byte};
            end
            8'b110?_????: begin
               acc_in  = {{(CpW-5){1'b0}}, req_data_byte[4:0]};
               held_in = 2'd1;
               need_in = 2'd1;
            end
            8'b1110_????: begin
               acc_in  = {{(CpW-4){1'b0}}, req_data_byte[3:0]};
               held_in = 2'd1;
               need_in = 2'd2;
            end
            8'b1111_0???: begin
               acc_in  = {{(CpW-3){1'b0}}, req_data_byte[2:0]};
               held_in = 2'd1;
               need_in = 2'd3;
            end
            default: begin
               job.has_tail = 1'b1;
               job.tail     = SpaceCp;
            end
         endcase
      end
   end

   assign push = accept && (job.spaces != 2'd0 || job.has_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         need_ff <= 2'd0;
         acc_ff  <= '0;
      end else if (accept) begin
         held_ff <= held_in;
         need_ff <= need_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8sd_queue.sv =====
`default_nettype none

module utf8sd_queue
   import utf8sd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire job_type    push_job,
   input  wire logic       pop,
   output job_type         head_job,
   output queue_status_type status
);

   job_type          slot_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;

   assign status.not_full  = count_ff != QCntW'(QDepth);
   assign status.not_empty = count_ff != '0;
   assign head_job         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8sd_back.sv =====
`default_nettype none

module utf8sd_back
   import utf8sd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire job_type        head_job,
   input  wire logic           head_valid,
   output      logic           pop,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   output      logic [CpW-1:0] rsp_code_point,
   output      logic           rsp_last_in_run
);

   logic [1:0]     sent_ff, sent_in;
   logic           valid_ff, valid_in;
   logic [CpW-1:0] cp_ff, cp_in;
   logic           last_ff, last_in;
   logic           load;
   logic           is_space;
   logic           is_last;

   assign load     = head_valid && (!valid_ff || rsp_ready);
   assign is_space = sent_ff < head_job.spaces;
   assign is_last  = head_job.has_tail ? (sent_ff == head_job.spaces)
                                       : (sent_ff + 2'd1 == head_job.spaces);
   assign pop      = load && is_last;

   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff;
      cp_in    = cp_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         cp_in    = is_space ? SpaceCp : head_job.tail;
         last_in  = is_last;
         // advance through the job, restart at zero once its last result is out
         sent_in  = is_last ? 2'd0 : sent_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
      cp_ff   <= cp_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_last_in_run = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder.sv =====
// An item's first result goes through the job queue and then the output register.
// One result per cycle leaves the output register while rsp_ready is high and jobs
// wait; an item is taken every cycle while the queue is not full.
// A four-entry job queue between decoder and output register absorbs stalls.
// Reset (synchronous, active high) clears the sequence state, the queue and rsp_valid.
`default_nettype none

module utf8_stream_decoder
   import utf8sd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic           req_end_of_text,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   output      logic [CpW-1:0] rsp_code_point,
   output      logic           rsp_last_in_run
);

   job_type          new_job;
   job_type          head_job;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   logic             accept;

   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;

   utf8sd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .job             (new_job)
   );

   utf8sd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (new_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   utf8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .head_valid      (q_status.not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/utf8sd_checker.sv =====
`default_nettype none

module utf8sd_checker
   import utf8sd_pkg::*;
(
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_ready,
   input wire logic           rsp_valid,
   input wire logic           rsp_ready,
   input wire logic [CpW-1:0] rsp_code_point,
   input wire logic           rsp_last_in_run
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_code_point) && $stable(rsp_last_in_run))
      else $error("rsp payload changed while stalled");

   // only dropped bytes come ahead of the final result of an item
   a_early_is_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_in_run |-> rsp_code_point == SpaceCp)
      else $error("non-final result is not a space");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle right after reset");

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (.*);

`default_nettype wire

// ===== verif/tb_utf8_stream_decoder.sv =====
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
   import utf8sd_pkg::*;

   localparam int CycleLimit = 400000;

   typedef struct {
      logic [CpW-1:0] cp;
      logic           last;
   } code_point_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   logic [7:0]     req_data_byte = 8'h00;
   logic           req_end_of_text = 1'b0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic [CpW-1:0] rsp_code_point;
   logic           rsp_last_in_run;

   // decoder state as the predictor sees it
   logic [1:0]     seq_held = '0;
   logic [1:0]     seq_need = '0;
   logic [CpW-1:0] seq_acc = '0;
   logic [CpW-1:0] step_cps[$];
   code_point_type expected_cps[$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic rsp_hold = 1'b0;
   int   items_sent = 0;
   int   results_checked = 0;
   int   spaces_checked = 0;
   int   wide_checked = 0;
   int   mismatches = 0;
   int   cycles = 0;

   utf8_stream_decoder dut (.*);

   initial forever #5 clock = ~clock;

   initial forever begin
      @(posedge clock);
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles, %0d code points still owed",
                  cycles, expected_cps.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR at cycle %0d: %s", cycles, msg);
   endtask

   // ---------------- prediction ----------------

   task automatic flush_held();
      repeat (seq_held) step_cps.push_back(SpaceCp);
      seq_held = '0;
      seq_need = '0;
      seq_acc  = '0;
   endtask

   task automatic open_byte(input logic [7:0] b);
      if (!b[7]) begin
         step_cps.push_back(CpW'(b));
      end else if (b[7:5] == 3'b110) begin
         seq_acc  = CpW'(b[4:0]);
         seq_held = 2'd1;
         seq_need = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         seq_acc  = CpW'(b[3:0]);
         seq_held = 2'd1;
         seq_need = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         seq_acc  = CpW'(b[2:0]);
         seq_held = 2'd1;
         seq_need = 2'd3;
      end else begin
         step_cps.push_back(SpaceCp);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eot);
      step_cps.delete();
      if (eot) begin
         flush_held();
      end else if (seq_held != 0 && seq_need != 0) begin
         if (b[7:6] == 2'b10) begin
            seq_acc  = {seq_acc[CpW-7:0], b[5:0]};
            seq_held = seq_held + 2'd1;
            seq_need = seq_need - 2'd1;
            if (seq_need == 0) begin
               step_cps.push_back(seq_acc);
               seq_held = '0;
               seq_acc  = '0;
            end
         end else begin
            // drop the open sequence, then treat the byte as a new lead
            flush_held();
            open_byte(b);
         end
      end else begin
         seq_held = '0;
         seq_need = '0;
         seq_acc  = '0;
         open_byte(b);
      end
      foreach (step_cps[i])
         expected_cps.push_back('{step_cps[i], i == step_cps.size() - 1});
   endtask

   // ---------------- result side ----------------

   initial forever begin
      @(posedge clock);
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      code_point_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_cps.size() == 0) begin
               flag_mismatch($sformatf("code point %06h with none expected", rsp_code_point));
            end else begin
               want = expected_cps.pop_front();
               results_checked++;
               if (want.cp == SpaceCp) spaces_checked++;
               if (want.cp > 21'h7F) wide_checked++;
               if (rsp_code_point !== want.cp)
                  flag_mismatch($sformatf("code_point %06h, wanted %06h",
                                          rsp_code_point, want.cp));
               if (rsp_last_in_run !== want.last)
                  flag_mismatch($sformatf("last_in_run %b on code point %06h, wanted %b",
                                          rsp_last_in_run, want.cp, want.last));
            end
         end
      end
   end

   // ---------------- input side ----------------

   task automatic send_item(input logic [7:0] b, input logic eot = 1'b0);
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, eot);
      items_sent++;
      // idle between items, with junk on the payload
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid       <= 1'b0;
         req_data_byte   <= 8'($urandom);
         req_end_of_text <= 1'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cps.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random_unit();
      int         pick;
      int         len;
      int         sent;
      logic [7:0] lead;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
         len = $urandom_range(1, 4);
         case (len)
            1: lead = 8'($urandom_range(0, 127));
            2: lead = 8'hC0 | 8'($urandom_range(0, 31));
            3: lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
         endcase
         // cut some sequences short so the next item breaks in
         sent = (pick < 70 || len == 1) ? len : $urandom_range(1, len - 1);
         send_item(lead);
         repeat (sent - 1) send_item(8'h80 | 8'($urandom_range(0, 63)));
      end else if (pick < 94) begin
         send_item(8'($urandom));
      end else begin
         send_item(8'($urandom), 1'b1);
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) send_random_unit();
      wait_drained();
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      logic [8:0] script [0:25];   // {end_of_text, data_byte}
      script = '{
         9'h000, 9'h07F,                         // plain bytes at both ends
         9'h0C3, 9'h0A9,                         // two-byte sequence
         9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,         // largest four-byte value
         9'h080, 9'h0F8,                         // stray continuation, invalid lead
         9'h0C3, 9'h0E2, 9'h082, 9'h0AC,         // lead breaks a lead, then three-byte
         9'h0E2, 9'h082, 9'h041,                 // ASCII breaks an open sequence
         9'h0F0, 9'h09F, 9'h098, 9'h0FF,         // invalid lead breaks three held bytes
         9'h0F0, 9'h09F, 9'h098, 9'h1C3, 9'h141  // flush held bytes, then nothing held
      };
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (script[i]) send_item(script[i][7:0], script[i][8]);
      wait_drained();
   endtask

   task automatic test_slow_receiver();
      send_idle_pct = 26;
      recv_idle_pct = 87;
      run_random(100);
   endtask

   task automatic test_slow_sender();
      send_idle_pct = 87;
      recv_idle_pct = 26;
      run_random(100);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(100);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            // hold results back long enough for the input to stall
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         run_random(40);
      join
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();
      test_backpressure();
      $display("Sent %0d bytes and end-of-text marks; checked %0d code points,",
               items_sent, results_checked);
      $display("%0d above 0x7F and %0d spaces, under mixed stalls and one long hold.",
               wide_checked, spaces_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_front.sv
hw/rtl/utf8sd_queue.sv
hw/rtl/utf8sd_back.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/utf8sd_checker.sv
verif/tb_utf8_stream_decoder.sv
